// ===== rtl/slr_pkg.sv =====
// Shared types and constants for the stereo linear resampler.
// Depends on nothing; imported by stereo_linear_resampler_core.
package slr_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int RATE_BITS  = 18;
   localparam int PHASE_BITS = RATE_BITS + 2;
   // Difference of two samples, and the quotient bits needed to cover it plus rounding.
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int QUO_W      = DIFF_W + 1;
   localparam int NUM_W      = DIFF_W + RATE_BITS + 1;
   localparam int STEP_W     = $clog2(QUO_W);
   localparam int MAX_OUT    = 8;
   localparam int CNT_W      = $clog2(MAX_OUT);

   localparam logic [RATE_BITS-1:0] INPUT_RATE_RESET  = RATE_BITS'(44100);
   localparam logic [RATE_BITS-1:0] OUTPUT_RATE_RESET = RATE_BITS'(44100);

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INPUT_RATE  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUTPUT_RATE = CSR_INDEX_BITS'(1);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] in_left;
      logic signed [SAMPLE_W-1:0] in_right;
   } req_data_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic                       last_of_run;
   } rsp_data_type;

endpackage

// ===== rtl/stereo_linear_resampler_core.sv =====
// Stereo linear-interpolation sample rate converter on an exact rational phase.
// Input pairs arrive on req_*, interpolated pairs leave on rsp_*, and the two
// rate registers are written on csr_*. Only the first transfer after reset is
// passed out unchanged; every later pair yields zero to eight output pairs,
// the final one of each run marked with last_of_run.
//
// req_ready is high only while the sequencer is idle. For each output pair,
// each channel in turn goes through one multiply, a rounding add, an absolute
// value, 18 steps of the shared restoring divider and a final add; then the
// output register is loaded. An input pair occupies the block until all of
// its outputs have passed through the single divider, one after another.
// Pairs that produce nothing are absorbed in the idle state; the first pair
// goes only through the load of the output register.
//
// A result waits in the output register while rsp_ready is low; computation of
// the next pair continues meanwhile and stalls only when it must load the
// register again. After the final result of a run is loaded the block accepts
// a new pair even if that result has not been taken yet. Synchronous reset
// clears the stream state and restores both rates to 44100.
module stereo_linear_resampler_core
   import slr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_data_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_data_type              rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [RATE_BITS-1:0]      csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ADD,
      S_ABS,
      S_DIV,
      S_FIN,
      S_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic                       started_ff, started_in;
   logic [RATE_BITS-1:0]       in_rate_ff, in_rate_in;
   logic [RATE_BITS-1:0]       out_rate_ff, out_rate_in;
   logic [PHASE_BITS-1:0]      phase_ff, phase_in;
   logic [PHASE_BITS-1:0]      pnext_ff, pnext_in;
   logic [SAMPLE_W-1:0]        held_l_ff, held_l_in;
   logic [SAMPLE_W-1:0]        held_r_ff, held_r_in;
   logic [SAMPLE_W-1:0]        cur_l_ff, cur_l_in;
   logic [SAMPLE_W-1:0]        cur_r_ff, cur_r_in;
   logic                       chan_ff, chan_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       last_ff, last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_data_type               rsp_data_ff, rsp_data_in;
   logic signed [NUM_W-1:0]    num_ff, num_in;
   logic                       neg_ff, neg_in;
   logic [RATE_BITS-1:0]       rem_ff, rem_in;
   logic [QUO_W-1:0]           quo_ff, quo_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [SAMPLE_W-1:0]        res_l_ff, res_l_in;
   logic [SAMPLE_W-1:0]        res_r_ff, res_r_in;

   logic [SAMPLE_W-1:0]        cur_sel;
   logic [SAMPLE_W-1:0]        prev_sel;
   logic signed [DIFF_W-1:0]   diff_s;
   logic signed [RATE_BITS:0]  ph_s;
   logic signed [NUM_W-1:0]    prod_s;
   logic [NUM_W-1:0]           num_u;
   logic [NUM_W-1:0]           mag;
   logic [RATE_BITS:0]         trial;
   logic                       trial_ge;
   logic [RATE_BITS:0]         trial_sub;
   logic signed [QUO_W:0]      quo_s;
   logic signed [QUO_W:0]      q_s;
   logic signed [QUO_W:0]      sum_s;
   logic                       pnext_gt;
   logic                       slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Datapath of the shared unit; the channel bit selects left or right.
   assign cur_sel  = chan_ff ? cur_r_ff : cur_l_ff;
   assign prev_sel = chan_ff ? held_r_ff : held_l_ff;
   assign diff_s   = $signed({cur_sel[SAMPLE_W-1], cur_sel})
                   - $signed({prev_sel[SAMPLE_W-1], prev_sel});
   assign ph_s     = $signed({1'b0, phase_ff[RATE_BITS-1:0]});
   assign prod_s   = diff_s * ph_s;
   assign num_u    = num_ff;
   assign mag      = num_ff[NUM_W-1] ? (~num_u + NUM_W'(1)) : num_u;
   assign trial    = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_ge = (trial >= {1'b0, out_rate_ff});
   assign trial_sub = trial - {1'b0, out_rate_ff};
   assign quo_s    = $signed({1'b0, quo_ff});
   assign q_s      = neg_ff ? -quo_s : quo_s;
   assign sum_s    = q_s + $signed({{(QUO_W + 1 - SAMPLE_W){prev_sel[SAMPLE_W-1]}}, prev_sel});
   assign pnext_gt = (pnext_ff > PHASE_BITS'(out_rate_ff));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      in_rate_in   = in_rate_ff;
      out_rate_in  = out_rate_ff;
      phase_in     = phase_ff;
      pnext_in     = pnext_ff;
      held_l_in    = held_l_ff;
      held_r_in    = held_r_ff;
      cur_l_in     = cur_l_ff;
      cur_r_in     = cur_r_ff;
      chan_in      = chan_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rsp_data_in  = rsp_data_ff;
      num_in       = num_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      res_l_in     = res_l_ff;
      res_r_in     = res_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_INPUT_RATE:  in_rate_in  = csr_data;
            CSR_OUTPUT_RATE: out_rate_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cur_l_in = req_data.in_left;
               cur_r_in = req_data.in_right;
               chan_in  = 1'b0;
               cnt_in   = '0;
               if (!started_ff) begin
                  // The first pair goes out unchanged and starts the phase.
                  started_in = 1'b1;
                  held_l_in  = req_data.in_left;
                  held_r_in  = req_data.in_right;
                  res_l_in   = req_data.in_left;
                  res_r_in   = req_data.in_right;
                  last_in    = 1'b1;
                  phase_in   = PHASE_BITS'(in_rate_ff);
                  state_in   = S_EMIT;
               end else if (out_rate_ff == '0) begin
                  held_l_in = req_data.in_left;
                  held_r_in = req_data.in_right;
               end else if (phase_ff > PHASE_BITS'(out_rate_ff)) begin
                  // No output point falls inside this interval.
                  held_l_in = req_data.in_left;
                  held_r_in = req_data.in_right;
                  phase_in  = phase_ff - PHASE_BITS'(out_rate_ff);
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            num_in = prod_s;
            if (!chan_ff) begin
               pnext_in = phase_ff + PHASE_BITS'(in_rate_ff);
            end
            state_in = S_ADD;
         end
         S_ADD: begin
            num_in   = num_ff + $signed(NUM_W'(out_rate_ff >> 1));
            state_in = S_ABS;
         end
         S_ABS: begin
            neg_in   = num_ff[NUM_W-1];
            rem_in   = mag[NUM_W-1:QUO_W];
            quo_in   = mag[QUO_W-1:0];
            step_in  = STEP_W'(QUO_W - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = trial_ge ? trial_sub[RATE_BITS-1:0] : trial[RATE_BITS-1:0];
            quo_in  = {quo_ff[QUO_W-2:0], trial_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!chan_ff) begin
               res_l_in = sum_s[SAMPLE_W-1:0];
               chan_in  = 1'b1;
               state_in = S_MUL;
            end else begin
               res_r_in = sum_s[SAMPLE_W-1:0];
               last_in  = (cnt_ff == CNT_W'(MAX_OUT - 1)) || pnext_gt;
               if ((cnt_ff == CNT_W'(MAX_OUT - 1)) || pnext_gt) begin
                  phase_in = pnext_gt ? (pnext_ff - PHASE_BITS'(out_rate_ff))
                                      : PHASE_BITS'(in_rate_ff);
               end else begin
                  phase_in = pnext_ff;
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.left_sample  = res_l_ff;
               rsp_data_in.right_sample = res_r_ff;
               rsp_data_in.last_of_run  = last_ff;
               if (last_ff) begin
                  held_l_in = cur_l_ff;
                  held_r_in = cur_r_ff;
                  state_in  = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff + CNT_W'(1);
                  chan_in  = 1'b0;
                  state_in = S_MUL;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      pnext_ff    <= pnext_in;
      cur_l_ff    <= cur_l_in;
      cur_r_ff    <= cur_r_in;
      rsp_data_ff <= rsp_data_in;
      num_ff      <= num_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      res_l_ff    <= res_l_in;
      res_r_ff    <= res_r_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         started_ff   <= 1'b0;
         in_rate_ff   <= INPUT_RATE_RESET;
         out_rate_ff  <= OUTPUT_RATE_RESET;
         phase_ff     <= '0;
         held_l_ff    <= '0;
         held_r_ff    <= '0;
         chan_ff      <= 1'b0;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         in_rate_ff   <= in_rate_in;
         out_rate_ff  <= out_rate_in;
         phase_ff     <= phase_in;
         held_l_ff    <= held_l_in;
         held_r_ff    <= held_r_in;
         chan_ff      <= chan_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The partial remainder of the divider always stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < out_rate_ff))
      else $error("divider remainder reached the divisor");

   // The eighth output of a run always closes the run.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && cnt_ff == CNT_W'(MAX_OUT - 1)) |-> last_ff)
      else $error("run continued past the output cap");

   // Closing a run makes the current pair the held pair.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && $past(state_ff) == S_EMIT && !$past(reset))
         |-> (held_l_ff == cur_l_ff && held_r_ff == cur_r_ff))
      else $error("held pair not updated at end of run");

   // Once the stream has started it stays started until reset.
   assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("started flag dropped without reset");

endmodule
